// ===== hdl/pssd_pkg.sv =====
// ----------------------------------------------------------------------------
// pssd_pkg
// Types, constants and the exponent table shared by the speaker decoder.
// ----------------------------------------------------------------------------
package pssd_pkg;

  localparam int NumClasses  = 7;
  localparam int NumSpeakers = 3;
  localparam int FifoDepth   = 4;
  localparam int DivSteps    = 17;

  localparam logic [16:0] Log2eQ16 = 17'd94548;

  typedef struct packed {
    logic signed [15:0] logit_0;
    logic signed [15:0] logit_1;
    logic signed [15:0] logit_2;
    logic signed [15:0] logit_3;
    logic signed [15:0] logit_4;
    logic signed [15:0] logit_5;
    logic signed [15:0] logit_6;
    logic               frame_last;
  } in_t;

  typedef struct packed {
    logic [15:0] activity_0;
    logic [15:0] activity_1;
    logic [15:0] activity_2;
    logic        run_last;
  } out_t;

  typedef struct packed {
    logic [18:0] sum;
    logic [17:0] num_0;
    logic [17:0] num_1;
    logic [17:0] num_2;
    logic        last;
  } share_t;

  function automatic logic [16:0] pow2_neg(input logic [4:0] k);
    logic [16:0] v;
    case (k)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd62757;
      5'd2:    v = 17'd60097;
      5'd3:    v = 17'd57549;
      5'd4:    v = 17'd55109;
      5'd5:    v = 17'd52773;
      5'd6:    v = 17'd50535;
      5'd7:    v = 17'd48393;
      5'd8:    v = 17'd46341;
      5'd9:    v = 17'd44376;
      5'd10:   v = 17'd42495;
      5'd11:   v = 17'd40693;
      5'd12:   v = 17'd38968;
      5'd13:   v = 17'd37316;
      5'd14:   v = 17'd35734;
      5'd15:   v = 17'd34219;
      5'd16:   v = 17'd32768;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/pssd_front.sv =====
// ----------------------------------------------------------------------------
// pssd_front
// Five-stage front end: maximum, scaled differences, exponent terms and sums.
// ----------------------------------------------------------------------------
module pssd_front
  import pssd_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  in_t    in_data,
  output logic   push,
  output share_t push_data,
  input  logic   fifo_full
);

  logic en;
  logic [4:0] v_r;
  logic signed [15:0] lg_r [NumClasses];
  logic signed [15:0] lg2_r [NumClasses];
  logic signed [15:0] mx_r;
  logic [24:0] y_r [NumClasses];
  logic [16:0] e_r [NumClasses];
  logic [4:0] last_r;
  share_t sh_r;

  logic signed [15:0] lg_in [NumClasses];
  logic signed [15:0] m01, m23, m45, m0123, m456, mx_nxt;

  assign en        = !(v_r[4] && fifo_full);
  assign in_ready  = en;
  assign push      = v_r[4] && !fifo_full;
  assign push_data = sh_r;

  assign lg_in[0] = in_data.logit_0;
  assign lg_in[1] = in_data.logit_1;
  assign lg_in[2] = in_data.logit_2;
  assign lg_in[3] = in_data.logit_3;
  assign lg_in[4] = in_data.logit_4;
  assign lg_in[5] = in_data.logit_5;
  assign lg_in[6] = in_data.logit_6;

  always_comb begin
    m01    = (lg_r[1] > lg_r[0]) ? lg_r[1] : lg_r[0];
    m23    = (lg_r[3] > lg_r[2]) ? lg_r[3] : lg_r[2];
    m45    = (lg_r[5] > lg_r[4]) ? lg_r[5] : lg_r[4];
    m0123  = (m23 > m01) ? m23 : m01;
    m456   = (lg_r[6] > m45) ? lg_r[6] : m45;
    mx_nxt = (m456 > m0123) ? m456 : m0123;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    logic signed [16:0] d;
    logic [32:0] prod;
    logic [4:0] idx;
    logic [16:0] hi, lo, m;
    logic [11:0] dlt;
    logic [23:0] ip;
    logic [8:0] n;
    if (en) begin
      last_r <= {last_r[3:0], in_data.frame_last};
      for (int c = 0; c < NumClasses; c++) begin
        lg_r[c]  <= lg_in[c];
        lg2_r[c] <= lg_r[c];
      end
      mx_r <= mx_nxt;
      for (int c = 0; c < NumClasses; c++) begin
        d        = 17'(mx_r) - 17'(lg2_r[c]);
        prod     = {1'b0, d[15:0]} * {16'd0, Log2eQ16};
        y_r[c]   <= prod[32:8];
      end
      for (int c = 0; c < NumClasses; c++) begin
        idx  = {1'b0, y_r[c][15:12]};
        hi   = pow2_neg(idx);
        lo   = pow2_neg(idx + 5'd1);
        dlt  = 12'(hi - lo);
        ip   = {12'd0, dlt} * {12'd0, y_r[c][11:0]};
        m    = hi - {5'd0, ip[23:12]};
        n    = y_r[c][24:16];
        e_r[c] <= (n > 9'd16) ? 17'd0 : (m >> n);
      end
      sh_r.sum   <= 19'(e_r[0]) + 19'(e_r[1]) + 19'(e_r[2]) + 19'(e_r[3])
                  + 19'(e_r[4]) + 19'(e_r[5]) + 19'(e_r[6]);
      sh_r.num_0 <= 18'(e_r[1]) + 18'(e_r[4]) + 18'(e_r[5]);
      sh_r.num_1 <= 18'(e_r[2]) + 18'(e_r[4]) + 18'(e_r[6]);
      sh_r.num_2 <= 18'(e_r[3]) + 18'(e_r[5]) + 18'(e_r[6]);
      sh_r.last  <= last_r[3];
    end
  end

endmodule

// ===== hdl/pssd_fifo.sv =====
// ----------------------------------------------------------------------------
// pssd_fifo
// Short register queue between the front end and the divider back end.
// ----------------------------------------------------------------------------
module pssd_fifo
  import pssd_pkg::*;
#(
  parameter int DEPTH = FifoDepth
)
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  share_t push_data,
  output logic   full,
  input  logic   pop,
  output logic   nempty,
  output share_t pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  share_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign full     = (cnt_r == (AW+1)'(DEPTH));
  assign nempty   = (cnt_r != '0);
  assign pop_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

// ===== hdl/pssd_back.sv =====
// ----------------------------------------------------------------------------
// pssd_back
// Pipelined restoring dividers, one quotient bit per stage, three lanes,
// followed by saturation and the output register.
// ----------------------------------------------------------------------------
module pssd_back
  import pssd_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   nempty,
  input  share_t pop_data,
  output logic   pop,
  output logic   out_valid,
  input  logic   out_ready,
  output out_t   out_data
);

  logic en;
  logic [DivSteps:0] v_r;
  logic [DivSteps:0] last_r;
  logic [18:0] s_r   [DivSteps+1];
  logic [18:0] rem_r [DivSteps+1][NumSpeakers];
  logic [16:0] low_r [DivSteps+1][NumSpeakers];
  logic [16:0] q_r   [DivSteps+1][NumSpeakers];
  logic        ov_r;
  out_t        od_r;
  logic [17:0] num_in [NumSpeakers];
  logic [15:0] act [NumSpeakers];

  assign en        = !(ov_r && !out_ready);
  assign pop       = en && nempty;
  assign out_valid = ov_r;
  assign out_data  = od_r;

  assign num_in[0] = pop_data.num_0;
  assign num_in[1] = pop_data.num_1;
  assign num_in[2] = pop_data.num_2;

  always_comb begin
    for (int l = 0; l < NumSpeakers; l++) begin
      act[l] = q_r[DivSteps][l][16] ? 16'hFFFF : q_r[DivSteps][l][15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= '0;
      ov_r <= 1'b0;
    end else if (en) begin
      v_r  <= {v_r[DivSteps-1:0], nempty};
      ov_r <= v_r[DivSteps];
    end
  end

  always_ff @(posedge clk) begin
    logic [33:0] nd;
    logic [19:0] t;
    if (en) begin
      s_r[0]    <= pop_data.sum;
      last_r[0] <= pop_data.last;
      for (int l = 0; l < NumSpeakers; l++) begin
        nd = {num_in[l], 16'd0} + 34'(pop_data.sum[18:1]);
        rem_r[0][l] <= {2'd0, nd[33:17]};
        low_r[0][l] <= nd[16:0];
        q_r[0][l]   <= '0;
      end
      for (int k = 0; k < DivSteps; k++) begin
        s_r[k+1]    <= s_r[k];
        last_r[k+1] <= last_r[k];
        for (int l = 0; l < NumSpeakers; l++) begin
          t = {rem_r[k][l], low_r[k][l][16]};
          if (t >= {1'b0, s_r[k]}) begin
            rem_r[k+1][l] <= 19'(t - {1'b0, s_r[k]});
            q_r[k+1][l]   <= {q_r[k][l][15:0], 1'b1};
          end else begin
            rem_r[k+1][l] <= t[18:0];
            q_r[k+1][l]   <= {q_r[k][l][15:0], 1'b0};
          end
          low_r[k+1][l] <= {low_r[k][l][15:0], 1'b0};
        end
      end
      od_r.activity_0 <= act[0];
      od_r.activity_1 <= act[1];
      od_r.activity_2 <= act[2];
      od_r.run_last   <= last_r[DivSteps];
    end
  end

endmodule

// ===== hdl/powerset_softmax_speaker_decode.sv =====
// ----------------------------------------------------------------------------
// powerset_softmax_speaker_decode
// Turns seven powerset class logits into three per-speaker activities.
//
// The input channel (in_valid, in_ready, in_data) takes one frame of seven
// signed Q8.8 logits and a last-frame flag per transaction. The output
// channel (out_valid, out_ready, out_data) returns one transaction per frame
// with three unsigned Q0.16 activities and the copied flag, in input order.
// One frame is accepted every cycle unless stalled. A frame passes five
// front stages (maximum, exponent, sums), the queue register, an input
// register, seventeen divider stages producing one quotient bit each, and
// the output register. A four-entry queue separates the front end from the
// dividers. When the receiver stalls, the divider pipeline holds, the queue
// fills and then the front end holds, which drops in_ready. The synchronous
// reset empties all pipelines and the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
module powerset_softmax_speaker_decode
  import pssd_pkg::*;
#(
  parameter int FIFO_DEPTH = FifoDepth
)
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic   push, full, pop, nempty;
  share_t push_data, pop_data;

  pssd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data),
    .fifo_full (full)
  );

  pssd_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .nempty    (nempty),
    .pop_data  (pop_data)
  );

  pssd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .nempty    (nempty),
    .pop_data  (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== verif/powerset_softmax_speaker_decode_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// powerset_softmax_speaker_decode_tb
// Self-checking testbench for the three-speaker powerset softmax decoder.
//
// A directed table of frames covers the logit extremes, ties, full certainty
// and vanishing terms. Random frames follow: mostly logits spread within
// 4 to 32 units, the rest over the full range or within a quarter unit. Each
// frame's activities are predicted in fixed point and queued in order. Every
// output transaction is compared with the oldest queued prediction. The
// sender works in bursts, the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module powerset_softmax_speaker_decode_tb;
  import pssd_pkg::*;

  localparam int NumRandom = 1750;
  localparam int Latency   = 24;
  localparam int IdleLimit = 20000;
  localparam int NumRows   = 16;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  out_t activity_queue[$];
  int   n_errors;
  int   idle_cycles;

  logic [16:0] exp_table[17] = '{
    17'd65536, 17'd62757, 17'd60097, 17'd57549, 17'd55109, 17'd52773,
    17'd50535, 17'd48393, 17'd46341, 17'd44376, 17'd42495, 17'd40693,
    17'd38968, 17'd37316, 17'd35734, 17'd34219, 17'd32768
  };

  in_t  row_frame[NumRows];
  out_t row_result[NumRows];
  bit   row_typed[NumRows];

  powerset_softmax_speaker_decode i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [16:0] exp_term(input logic [16:0] d);
    logic [33:0] y;
    logic [17:0] n;
    logic [15:0] f;
    logic [16:0] hi;
    logic [16:0] lo;
    logic [16:0] m;
    y = ({17'd0, d} * 34'd94548) >> 8;
    n = y[33:16];
    f = y[15:0];
    hi = exp_table[f[15:12]];
    lo = exp_table[f[15:12] + 1];
    m = hi - 17'(({12'd0, hi - lo} * {17'd0, f[11:0]}) >> 12);
    if (n > 16) begin
      return 17'd0;
    end
    return m >> n;
  endfunction

  function automatic out_t decode_frame(input in_t fr);
    logic signed [15:0] lg[7];
    logic [16:0]        e[7];
    logic signed [15:0] mx;
    logic [47:0]        total;
    logic [47:0]        num;
    logic [47:0]        share;
    logic [15:0]        act[3];
    out_t               res;
    lg = '{fr.logit_0, fr.logit_1, fr.logit_2, fr.logit_3, fr.logit_4,
           fr.logit_5, fr.logit_6};
    mx = lg[0];
    for (int c = 1; c < 7; c++) begin
      if (lg[c] > mx) begin
        mx = lg[c];
      end
    end
    total = '0;
    for (int c = 0; c < 7; c++) begin
      e[c] = exp_term(17'(32'(mx) - 32'(lg[c])));
      total += e[c];
    end
    for (int s = 0; s < 3; s++) begin
      case (s)
        0: num = 48'(e[1]) + e[4] + e[5];
        1: num = 48'(e[2]) + e[4] + e[6];
        default: num = 48'(e[3]) + e[5] + e[6];
      endcase
      share = (num * 65536 + total / 2) / total;
      act[s] = (share > 65535) ? 16'hFFFF : share[15:0];
    end
    res.activity_0 = act[0];
    res.activity_1 = act[1];
    res.activity_2 = act[2];
    res.run_last = fr.frame_last;
    return res;
  endfunction

  function automatic in_t make_frame(input int spread);
    in_t fr;
    logic signed [15:0] base;
    base = 16'($urandom_range(0, 65535));
    fr.logit_0 = (spread == 0) ? 16'($urandom) : base + 16'($urandom_range(0, spread));
    fr.logit_1 = (spread == 0) ? 16'($urandom) : base + 16'($urandom_range(0, spread));
    fr.logit_2 = (spread == 0) ? 16'($urandom) : base + 16'($urandom_range(0, spread));
    fr.logit_3 = (spread == 0) ? 16'($urandom) : base + 16'($urandom_range(0, spread));
    fr.logit_4 = (spread == 0) ? 16'($urandom) : base + 16'($urandom_range(0, spread));
    fr.logit_5 = (spread == 0) ? 16'($urandom) : base + 16'($urandom_range(0, spread));
    fr.logit_6 = (spread == 0) ? 16'($urandom) : base + 16'($urandom_range(0, spread));
    fr.frame_last = 1'($urandom);
    return fr;
  endfunction

  task automatic send_frame(input in_t fr, input bit typed, input out_t typed_res);
    in_valid <= 1'b1;
    in_data <= fr;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    if (typed) begin
      activity_queue.insert(activity_queue.size(), typed_res);
    end else begin
      activity_queue.insert(activity_queue.size(), decode_frame(fr));
    end
  endtask

  task automatic maybe_gap();
    int gap;
    if ($urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    in_frame_rows();
  end

  task automatic in_frame_rows();
    in_t z;
    z = '0;
    for (int i = 0; i < NumRows; i++) begin
      row_frame[i] = z;
      row_typed[i] = 1'b0;
      row_result[i] = '0;
    end
    // All equal: every class gets one seventh, each speaker three sevenths.
    row_frame[0] = z;
    row_frame[1] = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                     16'sh7FFF, 16'sh7FFF, 1'b1};
    row_frame[2] = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                     16'sh8000, 16'sh8000, 1'b0};
    // Silence certain: all other terms vanish.
    row_frame[3] = '{16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                     16'sh8000, 16'sh8000, 1'b1};
    row_typed[3] = 1'b1;
    row_result[3] = '{16'd0, 16'd0, 16'd0, 1'b1};
    // Speaker one alone certain saturates.
    row_frame[4] = '{16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000,
                     16'sh8000, 16'sh8000, 1'b0};
    row_typed[4] = 1'b1;
    row_result[4] = '{16'hFFFF, 16'd0, 16'd0, 1'b0};
    // Pair of speakers two and three certain.
    row_frame[5] = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                     16'sh8000, 16'sh7FFF, 1'b1};
    row_typed[5] = 1'b1;
    row_result[5] = '{16'd0, 16'hFFFF, 16'hFFFF, 1'b1};
    row_frame[6] = '{16'sh0000, 16'sh0100, 16'sh0100, 16'sh0000, 16'shFF00,
                     16'sh0200, 16'sh0000, 1'b0};
    row_frame[7] = '{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000,
                     16'sh0000, 16'sh0B00, 1'b0};
    row_frame[8] = '{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0C00, 16'sh0000,
                     16'sh0000, 16'sh0000, 1'b1};
    row_frame[9] = '{16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA,
                     16'sh5555, 16'shAAAA, 1'b0};
    row_frame[10] = '{16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555,
                      16'shAAAA, 16'sh5555, 1'b1};
    row_frame[11] = '{16'sh0001, 16'sh0000, 16'shFFFF, 16'sh0002, 16'sh0003,
                      16'shFFFE, 16'sh0001, 1'b0};
    row_frame[12] = '{16'sh0000, 16'sh0A00, 16'sh0A00, 16'sh0A00, 16'sh0000,
                      16'sh0000, 16'sh0000, 1'b1};
    row_frame[13] = '{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0500,
                      16'sh0500, 16'sh0500, 1'b0};
    row_frame[14] = '{16'sh0000, 16'sh8000, 16'sh0000, 16'sh8000, 16'sh7FFF,
                      16'sh0000, 16'sh8000, 1'b1};
    row_frame[15] = '{16'sh1234, 16'sh1200, 16'sh1180, 16'sh1111, 16'sh1300,
                      16'sh1290, 16'sh1201, 1'b0};
  endtask

  initial begin
    int sent;
    n_errors = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < NumRows; i++) begin
      send_frame(row_frame[i], row_typed[i], row_result[i]);
    end
    sent = 0;
    while (sent < NumRandom) begin
      int burst;
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst && sent < NumRandom; b++) begin
        int pick;
        pick = $urandom_range(0, 9);
        send_frame(make_frame(pick < 6 ? 16'h0400 << ($urandom_range(0, 3)) :
                              pick < 8 ? 0 : 16'h0040), 1'b0, '0);
        sent++;
        if (sent == NumRandom / 2) begin
          in_valid <= 1'b0;
          while (activity_queue.size() != 0) begin
            @(posedge clk);
          end
        end
      end
      maybe_gap();
    end
    in_valid <= 1'b0;
    while (activity_queue.size() != 0) begin
      @(posedge clk);
    end
    repeat (Latency + 8) @(posedge clk);
    if (n_errors == 0) begin
      $display("[powerset_softmax_speaker_decode] OK");
    end else begin
      $display("[powerset_softmax_speaker_decode] ERROR");
    end
    $finish;
  end

  initial begin
    int mode;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      mode = $urandom_range(0, 2);
      if (mode == 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(10, 80)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (activity_queue.size() == 0) begin
        $display("%0t: unexpected transaction, actual %h", $time, out_data);
        n_errors++;
      end else begin
        want = activity_queue.pop_front();
        if (out_data.activity_0 !== want.activity_0) begin
          $display("%0t: activity_0 expected %0d actual %0d", $time,
                   want.activity_0, out_data.activity_0);
          n_errors++;
        end
        if (out_data.activity_1 !== want.activity_1) begin
          $display("%0t: activity_1 expected %0d actual %0d", $time,
                   want.activity_1, out_data.activity_1);
          n_errors++;
        end
        if (out_data.activity_2 !== want.activity_2) begin
          $display("%0t: activity_2 expected %0d actual %0d", $time,
                   want.activity_2, out_data.activity_2);
          n_errors++;
        end
        if (out_data.run_last !== want.run_last) begin
          $display("%0t: run_last expected %0d actual %0d", $time,
                   want.run_last, out_data.run_last);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("[powerset_softmax_speaker_decode] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ===== sim.f =====
hdl/pssd_pkg.sv
hdl/pssd_front.sv
hdl/pssd_fifo.sv
hdl/pssd_back.sv
hdl/powerset_softmax_speaker_decode.sv
verif/powerset_softmax_speaker_decode_tb.sv
